// ----- hdl/drti_pkg.sv -----
// ----------------------------------------------------------------------------
// drti_pkg
// Shared types and constants for the double round-to-integral unit.
// ----------------------------------------------------------------------------
package drti_pkg;

    localparam int unsigned WORD_W    = 64;
    localparam int unsigned EXP_W     = 11;
    localparam int unsigned FRAC_W    = 52;
    localparam int unsigned SHIFT_W   = 6;
    localparam logic [EXP_W-1:0] EXP_BIAS  = 11'd1023;
    localparam logic [EXP_W-1:0] EXP_INTEG = 11'd1075;
    localparam logic [WORD_W-1:0] ONE_BITS = 64'h3FF0_0000_0000_0000;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        FN_FLOOR = 2'd0,
        FN_CEIL  = 2'd1,
        FN_ROUND = 2'd2,
        FN_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CLS_PASS  = 2'd0,
        CLS_SMALL = 2'd1,
        CLS_FRAC  = 2'd2
    } cls_t;

    // classified word handed from front to back
    typedef struct packed {
        logic [WORD_W-1:0]  bits;
        cls_t               cls;
        logic               up_small;
        logic [SHIFT_W-1:0] fbits;
        func_t              func;
    } work_t;

endpackage

// ----- hdl/drti_front.sv -----
// ----------------------------------------------------------------------------
// drti_front
// Input register and classification of the operand.
// ----------------------------------------------------------------------------
module drti_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  func,
    input  logic [drti_pkg::WORD_W-1:0] value_bits,
    output logic                        work_valid,
    input  logic                        work_stall,
    output drti_pkg::work_t             work
);

    logic            valid_reg;
    drti_pkg::work_t work_reg;
    drti_pkg::work_t work_next;
    logic [drti_pkg::EXP_W-1:0] e;
    logic            neg;
    logic            take;

    assign e    = value_bits[62:52];
    assign neg  = value_bits[63];
    assign take = in_valid && !in_stall;
    assign in_stall = valid_reg && work_stall;

    always_comb
    begin
        work_next          = '0;
        work_next.bits     = value_bits;
        work_next.func     = drti_pkg::func_t'(func);
        work_next.fbits    = drti_pkg::SHIFT_W'(drti_pkg::EXP_INTEG - e);
        unique case (func)
            drti_pkg::FN_FLOOR: work_next.up_small = neg;
            drti_pkg::FN_CEIL:  work_next.up_small = !neg;
            default:            work_next.up_small = (e == drti_pkg::EXP_BIAS - 11'd1);
        endcase
        priority if (func == drti_pkg::FN_NONE || e >= drti_pkg::EXP_INTEG
                     || value_bits[62:0] == '0)
            work_next.cls = drti_pkg::CLS_PASS;
        else if (e < drti_pkg::EXP_BIAS)
            work_next.cls = drti_pkg::CLS_SMALL;
        else
            work_next.cls = drti_pkg::CLS_FRAC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            work_reg <= work_next;
    end

    assign work_valid = valid_reg;
    assign work       = work_reg;

endmodule

// ----- hdl/drti_queue.sv -----
// ----------------------------------------------------------------------------
// drti_queue
// Short FIFO decoupling classification from rounding.
// ----------------------------------------------------------------------------
module drti_queue
#(
    parameter int unsigned DEPTH = drti_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_stall,
    input  drti_pkg::work_t wr_data,
    output logic            rd_valid,
    input  logic            rd_stall,
    output drti_pkg::work_t rd_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    drti_pkg::work_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] rp_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push;
    logic             pop;

    assign wr_stall = (cnt_reg == CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;
    assign rd_data  = slot_reg[rp_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= bump(wp_reg);
            if (pop)
                rp_reg <= bump(rp_reg);
            if (push && !pop)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= wr_data;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop && cnt_reg != CNT_W'(DEPTH) |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("queue count lost a push");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wp_reg == rp_reg))
        else $error("empty queue with pointers apart");

endmodule

// ----- hdl/drti_back.sv -----
// ----------------------------------------------------------------------------
// drti_back
// Rounding datapath and output register.
// ----------------------------------------------------------------------------
module drti_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        work_valid,
    output logic                        work_stall,
    input  drti_pkg::work_t             work,
    output logic                        valid,
    input  logic                        stall,
    output logic [drti_pkg::WORD_W-1:0] result_bits
);

    logic                        valid_reg;
    logic [drti_pkg::WORD_W-1:0] res_reg;
    logic [drti_pkg::WORD_W-1:0] res_next;
    logic [drti_pkg::WORD_W-1:0] unit;
    logic [drti_pkg::WORD_W-1:0] mask;
    logic [drti_pkg::WORD_W-1:0] t;
    logic                        inc;
    logic                        neg;

    assign neg        = work.bits[63];
    assign unit       = drti_pkg::WORD_W'(1) << work.fbits;
    assign mask       = unit - drti_pkg::WORD_W'(1);
    assign t          = work.bits & ~mask;
    assign work_stall = valid_reg && stall;

    always_comb
    begin
        unique case (work.func)
            drti_pkg::FN_FLOOR: inc = neg;
            drti_pkg::FN_CEIL:  inc = !neg;
            default:            inc = |(work.bits & (unit >> 1));
        endcase
        unique case (work.cls)
            drti_pkg::CLS_SMALL:
                res_next = {neg, 63'd0} | (work.up_small ? drti_pkg::ONE_BITS : '0);
            drti_pkg::CLS_FRAC:
                res_next = ((work.bits & mask) == '0) ? work.bits
                         : (inc ? t + unit : t);
            default:
                res_next = work.bits;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!work_stall)
            valid_reg <= work_valid;
    end

    always_ff @(posedge clk)
    begin
        if (work_valid && !work_stall)
            res_reg <= res_next;
    end

    assign valid       = valid_reg;
    assign result_bits = res_reg;

endmodule

// ----- hdl/double_round_to_integral_unit.sv -----
// ----------------------------------------------------------------------------
// double_round_to_integral_unit
// Floor, ceil, round-half-away or pass-through (FN_NONE) of a binary64 word.
//
//  channel | signals                              | dir
//  in      | in_valid, in_stall, func, value_bits | in
//  out     | valid, stall, result_bits            | out
//
// One word per cycle while no stall holds; three register stages (front, queue,
// output), which a word passes in that order on its way to result_bits.
// Reset clears all valid flags and queue pointers; no clearing pass.
// Stalls back up through the queue; the front keeps taking words until full.
// ----------------------------------------------------------------------------
module double_round_to_integral_unit
#(
    parameter int unsigned QUEUE_DEPTH = drti_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  func,
    input  logic [drti_pkg::WORD_W-1:0] value_bits,
    output logic                        valid,
    input  logic                        stall,
    output logic [drti_pkg::WORD_W-1:0] result_bits
);

    logic            f_valid;
    logic            f_stall;
    drti_pkg::work_t f_work;
    logic            q_valid;
    logic            q_stall;
    drti_pkg::work_t q_work;

    drti_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .value_bits (value_bits),
        .work_valid (f_valid),
        .work_stall (f_stall),
        .work       (f_work)
    );

    drti_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_stall (f_stall),
        .wr_data  (f_work),
        .rd_valid (q_valid),
        .rd_stall (q_stall),
        .rd_data  (q_work)
    );

    drti_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .work_valid  (q_valid),
        .work_stall  (q_stall),
        .work        (q_work),
        .valid       (valid),
        .stall       (stall),
        .result_bits (result_bits)
    );

endmodule
